/* rtl/core/assert_macros.svh */
// Assertion macros for the quaternion-to-Euler core.
// No dependencies; included by the module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/qte_pkg.sv */
// Package for the quaternion-to-Euler core: widths, register indexes,
// the arctangent table, cell data types and small datapath functions.
// No dependencies.
package qte_pkg;

  localparam int CORDIC_STAGES_DEF = 16;

  // Field and datapath widths
  localparam int Q_W      = 32;   // quaternion part, Q2.30
  localparam int QF       = 30;   // fraction bits
  localparam int PROD_W   = 34;   // floored product, Q.30
  localparam int VEC_W    = 36;   // atan2 operand before the CORDIC
  localparam int CW       = 38;   // CORDIC x / y
  localparam int ZW       = 34;   // CORDIC angle, binary angle units
  localparam int TURN_SH  = 32;   // 2^32 units per turn
  localparam int SQ_W     = 61;   // square root radicand
  localparam int SQ_N     = 31;   // root bits, one cell each
  localparam int DIV_BITS = 19;   // magnitude bits of ten times a rate
  localparam int ANG_W    = 17;
  localparam int RATE_W   = 16;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_PITCH_OFF = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROLL_OFF  = 2'd1;
  localparam logic [IDX_W-1:0] REG_YAW_OFF   = 2'd2;
  localparam logic [IDX_W-1:0] REG_RATE_DIV  = 2'd3;
  localparam logic [CFG_W-1:0] RATE_DIV_RST  = 16'd16;

  // Angle constants, centidegrees
  localparam logic signed [ANG_W-1:0] HALF_CDEG = 17'sd18000;
  localparam logic signed [ANG_W-1:0] TURN_CDEG = 17'sd36000;

  // atan(2^-i) in binary angle units
  localparam logic [29:0] ATAN_TAB [32] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
    30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
    30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
    30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
    30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001,
    30'h00000001, 30'h00000000
  };

  // Square root cell data
  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] r;
  } sqrt_t;

  // Divider cell data
  typedef struct packed {
    logic                neg;
    logic [DIV_BITS-1:0] num;
    logic [CFG_W-1:0]    rem;
    logic [DIV_BITS-1:0] quo;
  } div_t;

  // CORDIC cell data
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  // Operands that travel alongside the square root
  typedef struct packed {
    logic signed [Q_W-1:0]   s;
    logic signed [VEC_W-1:0] rl_y;
    logic signed [VEC_W-1:0] rl_x;
    logic signed [VEC_W-1:0] yw_y;
    logic signed [VEC_W-1:0] yw_x;
  } side_t;

  // Exact product floored to Q.30
  function automatic logic signed [PROD_W-1:0] mul_q30(
    input logic signed [Q_W-1:0] a,
    input logic signed [Q_W-1:0] b
  );
    logic signed [2*Q_W-1:0] p;
    p = a * b;
    return p[2*Q_W-1:QF];
  endfunction

  // Quadrant fold ahead of the vectoring CORDIC
  function automatic cordic_t cordic_prep(
    input logic signed [VEC_W-1:0] vy,
    input logic signed [VEC_W-1:0] vx
  );
    cordic_t c;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic signed [ZW-1:0] half;
    ex     = CW'(vx);
    ey     = CW'(vy);
    half   = ZW'(64'd1 << (TURN_SH - 1));
    c.zero = (vx == '0) && (vy == '0);
    if (vx[VEC_W-1]) begin
      c.x = -ex;
      c.y = -ey;
      c.z = vy[VEC_W-1] ? -half : half;
    end else begin
      c.x = ex;
      c.y = ey;
      c.z = '0;
    end
    return c;
  endfunction

  // Binary angle times 36000 to centidegrees, rounded half up, clamped
  function automatic logic signed [ANG_W-1:0] cdeg_round(
    input logic signed [ZW+ANG_W-1:0] p,
    input logic                       zero
  );
    logic signed [ZW+ANG_W:0]         t;
    logic signed [ZW+ANG_W-TURN_SH:0] q;
    logic signed [ZW+ANG_W-TURN_SH:0] lim;
    logic signed [ANG_W-1:0]          r;
    t   = (ZW+ANG_W+1)'(p) + (ZW+ANG_W+1)'(64'd1 << (TURN_SH - 1));
    q   = t[ZW+ANG_W:TURN_SH];
    lim = (ZW+ANG_W-TURN_SH+1)'(HALF_CDEG);
    if (zero)
      r = '0;
    else if (q > lim)
      r = HALF_CDEG;
    else if (q < -lim)
      r = -HALF_CDEG;
    else
      r = ANG_W'(q);
    return r;
  endfunction

  // Offset removal with the +-180 / 360 wrap, then saturation
  function automatic logic signed [ANG_W-1:0] wrap_off(
    input logic signed [ANG_W-1:0] a,
    input logic signed [CFG_W-1:0] e
  );
    logic signed [ANG_W+1:0] ax;
    logic signed [ANG_W+1:0] ex;
    logic signed [ANG_W+1:0] hf;
    logic signed [ANG_W+1:0] tn;
    logic signed [ANG_W+1:0] r;
    ax = (ANG_W+2)'(a);
    ex = (ANG_W+2)'(e);
    hf = (ANG_W+2)'(HALF_CDEG);
    tn = (ANG_W+2)'(TURN_CDEG);
    if (ex > 0)
      r = (ax > ex - hf) ? ax - ex : ax + tn - ex;
    else
      r = (ax < ex + hf) ? ax - ex : ax - ex - tn;
    if (r > tn)
      r = tn;
    else if (r < -tn)
      r = -tn;
    return ANG_W'(r);
  endfunction

  // Divider seed: magnitude and sign of ten times the raw rate
  function automatic div_t div_seed(input logic signed [RATE_W-1:0] raw);
    div_t d;
    logic signed [DIV_BITS:0] p;
    p     = (DIV_BITS+1)'(raw) * (DIV_BITS+1)'(10);
    d.neg = p[DIV_BITS];
    d.num = d.neg ? DIV_BITS'(-p) : DIV_BITS'(p);
    d.rem = '0;
    d.quo = '0;
    return d;
  endfunction

  // Signed quotient saturated to 16 bits
  function automatic logic signed [RATE_W-1:0] sat_rate(
    input logic                neg,
    input logic [DIV_BITS-1:0] q
  );
    logic signed [DIV_BITS:0] v;
    logic signed [DIV_BITS:0] hi;
    logic signed [DIV_BITS:0] lo;
    logic signed [RATE_W-1:0] r;
    v  = (DIV_BITS+1)'(q);
    hi = (DIV_BITS+1)'(17'sd32767);
    lo = -(DIV_BITS+1)'(20'sd32768);
    if (neg)
      v = -v;
    if (v > hi)
      r = RATE_W'(hi);
    else if (v < lo)
      r = RATE_W'(lo);
    else
      r = RATE_W'(v);
    return r;
  endfunction

endpackage

/* rtl/core/quaternion_to_euler_offset.sv */
// Quaternion to Euler angles with zero-offset removal and gyro rate scaling.
// Takes one Q2.30 quaternion and three raw rates per transaction and returns
// pitch, roll and yaw in centidegrees plus three scaled rates. Fully pipelined:
// a new transaction is taken every cycle while the output is not stalled, and
// each one passes through the products, the 31-cell square root chain, the
// CORDIC cell chains, the angle conversion and the output register.
// A stalled output holds the whole pipeline until the result is taken.
// Depends on qte_pkg, qte_delay, qte_sqrt_cell, qte_div_cell,
// qte_cordic_cell and assert_macros.svh.
`include "assert_macros.svh"

module quaternion_to_euler_offset #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [qte_pkg::Q_W-1:0]      in_quat_w,
  input  logic signed [qte_pkg::Q_W-1:0]      in_quat_x,
  input  logic signed [qte_pkg::Q_W-1:0]      in_quat_y,
  input  logic signed [qte_pkg::Q_W-1:0]      in_quat_z,
  input  logic signed [qte_pkg::RATE_W-1:0]   in_rate_x_raw,
  input  logic signed [qte_pkg::RATE_W-1:0]   in_rate_y_raw,
  input  logic signed [qte_pkg::RATE_W-1:0]   in_rate_z_raw,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [qte_pkg::ANG_W-1:0]    out_pitch_angle,
  output logic signed [qte_pkg::ANG_W-1:0]    out_roll_angle,
  output logic signed [qte_pkg::ANG_W-1:0]    out_yaw_angle,
  output logic signed [qte_pkg::RATE_W-1:0]   out_rate_x_scaled,
  output logic signed [qte_pkg::RATE_W-1:0]   out_rate_y_scaled,
  output logic signed [qte_pkg::RATE_W-1:0]   out_rate_z_scaled,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qte_pkg::IDX_W-1:0]           cfg_index,
  input  logic [qte_pkg::CFG_W-1:0]           cfg_data
);

  localparam int QW  = qte_pkg::Q_W;
  localparam int PW  = qte_pkg::PROD_W;
  localparam int VW  = qte_pkg::VEC_W;
  localparam int SW  = qte_pkg::SQ_W;
  localparam int SN  = qte_pkg::SQ_N;
  localparam int DB  = qte_pkg::DIV_BITS;
  localparam int AW  = qte_pkg::ANG_W;
  localparam int RW  = qte_pkg::RATE_W;
  localparam int FW  = qte_pkg::CFG_W;
  localparam int MW  = qte_pkg::ZW + qte_pkg::ANG_W;
  localparam int NS  = CORDIC_STAGES;
  localparam int NA  = 3;
  localparam int LAT = SN + NS + 6;      // stages ahead of the output register
  localparam int SQ_LAST = SN + 2;       // valid tap of the last root cell

  localparam int ANG_PITCH = 0;
  localparam int ANG_ROLL  = 1;
  localparam int ANG_YAW   = 2;

  localparam logic signed [VW-1:0] ONE_V  = VW'(64'd1 << qte_pkg::QF);
  localparam logic [SW-1:0]        TWO_60 = SW'(1) << (2 * qte_pkg::QF);
  localparam logic signed [AW-1:0] ANG_MAX = qte_pkg::TURN_CDEG;
  localparam logic signed [AW-1:0] ANG_HALF = qte_pkg::HALF_CDEG;

  // ---------------------------------------------------------------------
  // Handshake: whole pipeline advances when the output slot is free
  logic adv;
  logic out_valid_r;
  logic [LAT-1:0] vld_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT-2:0], in_valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // ---------------------------------------------------------------------
  // Configuration registers
  logic signed [FW-1:0] pitch_off_r;
  logic signed [FW-1:0] roll_off_r;
  logic signed [FW-1:0] yaw_off_r;
  logic [FW-1:0]        rate_div_r;
  logic [FW-1:0]        div_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_off_r <= '0;
      roll_off_r  <= '0;
      yaw_off_r   <= '0;
      rate_div_r  <= qte_pkg::RATE_DIV_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        qte_pkg::REG_PITCH_OFF: pitch_off_r <= cfg_data;
        qte_pkg::REG_ROLL_OFF:  roll_off_r  <= cfg_data;
        qte_pkg::REG_YAW_OFF:   yaw_off_r   <= cfg_data;
        qte_pkg::REG_RATE_DIV:  rate_div_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // a zero divisor acts as one
  assign div_eff = (rate_div_r == '0) ? FW'(1) : rate_div_r;

  // ---------------------------------------------------------------------
  // Stage 1: quaternion products, floored to Q.30
  logic signed [PW-1:0] p_xz_r, p_wy_r, p_yz_r, p_wx_r, p_xx_r;
  logic signed [PW-1:0] p_yy_r, p_xy_r, p_wz_r, p_ww_r, p_zz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_xz_r <= qte_pkg::mul_q30(in_quat_x, in_quat_z);
      p_wy_r <= qte_pkg::mul_q30(in_quat_w, in_quat_y);
      p_yz_r <= qte_pkg::mul_q30(in_quat_y, in_quat_z);
      p_wx_r <= qte_pkg::mul_q30(in_quat_w, in_quat_x);
      p_xx_r <= qte_pkg::mul_q30(in_quat_x, in_quat_x);
      p_yy_r <= qte_pkg::mul_q30(in_quat_y, in_quat_y);
      p_xy_r <= qte_pkg::mul_q30(in_quat_x, in_quat_y);
      p_wz_r <= qte_pkg::mul_q30(in_quat_w, in_quat_z);
      p_ww_r <= qte_pkg::mul_q30(in_quat_w, in_quat_w);
      p_zz_r <= qte_pkg::mul_q30(in_quat_z, in_quat_z);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: atan2 / asin operands
  logic signed [VW-1:0] s_dbl, s_clp;
  logic signed [QW-1:0] s_r;
  logic signed [VW-1:0] rl_y_r, rl_x_r, yw_y_r, yw_x_r;

  always_comb begin
    s_dbl = (VW'(p_xz_r) - VW'(p_wy_r)) <<< 1;
    if (s_dbl > ONE_V)
      s_clp = ONE_V;
    else if (s_dbl < -ONE_V)
      s_clp = -ONE_V;
    else
      s_clp = s_dbl;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r    <= QW'(s_clp);
      rl_y_r <= (VW'(p_yz_r) + VW'(p_wx_r)) <<< 1;
      rl_x_r <= ONE_V - ((VW'(p_xx_r) + VW'(p_yy_r)) <<< 1);
      yw_y_r <= (VW'(p_xy_r) + VW'(p_wz_r)) <<< 1;
      yw_x_r <= VW'(p_ww_r) + VW'(p_xx_r) - VW'(p_yy_r) - VW'(p_zz_r);
    end
  end

  // Side operands wait out the square root
  qte_pkg::side_t side_in;
  qte_pkg::side_t side_q;

  always_comb begin
    side_in.s    = s_r;
    side_in.rl_y = rl_y_r;
    side_in.rl_x = rl_x_r;
    side_in.yw_y = yw_y_r;
    side_in.yw_x = yw_x_r;
  end

  qte_delay #(
    .W ($bits(qte_pkg::side_t)),
    .N (SN + 1)
  ) u_side_dly (
    .clk (clk),
    .en  (adv),
    .d   (side_in),
    .q   (side_q)
  );

  // ---------------------------------------------------------------------
  // Stage 3: radicand 1 - s^2
  logic signed [2*QW-1:0] s_sq;
  logic [SW-1:0]          v_r;

  assign s_sq = s_r * s_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r <= TWO_60 - SW'(s_sq);
    end
  end

  // Square root cell chain, one root bit per cell
  qte_pkg::sqrt_t sq_w [SN+1];

  assign sq_w[0] = {v_r, SW'(0)};

  for (genvar i = 0; i < SN; i++) begin : g_sqrt
    qte_sqrt_cell #(
      .K (SN - 1 - i)
    ) u_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (sq_w[i]),
      .d_out (sq_w[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Quadrant fold for the three CORDIC chains
  qte_pkg::cordic_t prep_r [NA];

  always_ff @(posedge clk) begin
    if (adv) begin
      prep_r[ANG_PITCH] <= qte_pkg::cordic_prep(VW'(side_q.s), VW'(sq_w[SN].r));
      prep_r[ANG_ROLL]  <= qte_pkg::cordic_prep(side_q.rl_y, side_q.rl_x);
      prep_r[ANG_YAW]   <= qte_pkg::cordic_prep(side_q.yw_y, side_q.yw_x);
    end
  end

  // CORDIC cell chains
  qte_pkg::cordic_t cd_w [NA][NS+1];

  for (genvar a = 0; a < NA; a++) begin : g_ang
    assign cd_w[a][0] = prep_r[a];
    for (genvar j = 0; j < NS; j++) begin : g_cell
      qte_cordic_cell #(
        .STAGE (j)
      ) u_cell (
        .clk   (clk),
        .en    (adv),
        .d_in  (cd_w[a][j]),
        .d_out (cd_w[a][j+1])
      );
    end
  end

  // ---------------------------------------------------------------------
  // Binary angle to centidegrees: scale, then round and clamp
  logic signed [MW-1:0] mul_r [NA];
  logic                 mz_r  [NA];
  logic signed [AW-1:0] ang_nxt [NA];
  logic signed [AW-1:0] ang_r   [NA];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < NA; a++) begin
        mul_r[a] <= cd_w[a][NS].z * qte_pkg::TURN_CDEG;
        mz_r[a]  <= cd_w[a][NS].zero;
      end
    end
  end

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      ang_nxt[a] = qte_pkg::cdeg_round(mul_r[a], mz_r[a]);
    end
    // roll is turned by half a revolution
    if (ang_nxt[ANG_ROLL][AW-1])
      ang_nxt[ANG_ROLL] = ang_nxt[ANG_ROLL] + ANG_HALF;
    else
      ang_nxt[ANG_ROLL] = ang_nxt[ANG_ROLL] - ANG_HALF;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < NA; a++) begin
        ang_r[a] <= ang_nxt[a];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Rate scaling: divider chains, then a delay to line up with the angles
  logic signed [RW-1:0] raw [NA];
  qte_pkg::div_t        div_w [NA][DB+1];
  logic [NA*RW-1:0]     rate_in;
  logic [NA*RW-1:0]     rate_q;

  assign raw[0] = in_rate_x_raw;
  assign raw[1] = in_rate_y_raw;
  assign raw[2] = in_rate_z_raw;

  for (genvar a = 0; a < NA; a++) begin : g_rate
    assign div_w[a][0] = qte_pkg::div_seed(raw[a]);
    for (genvar i = 0; i < DB; i++) begin : g_cell
      qte_div_cell #(
        .BIT (DB - 1 - i)
      ) u_cell (
        .clk     (clk),
        .en      (adv),
        .divisor (div_eff),
        .d_in    (div_w[a][i]),
        .d_out   (div_w[a][i+1])
      );
    end
    assign rate_in[a*RW +: RW] = qte_pkg::sat_rate(div_w[a][DB].neg, div_w[a][DB].quo);
  end

  qte_delay #(
    .W (NA * RW),
    .N (LAT - DB)
  ) u_rate_dly (
    .clk (clk),
    .en  (adv),
    .d   (rate_in),
    .q   (rate_q)
  );

  // ---------------------------------------------------------------------
  // Output register: offset removal
  logic signed [AW-1:0] out_pitch_r, out_roll_r, out_yaw_r;
  logic signed [RW-1:0] out_rx_r, out_ry_r, out_rz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pitch_r <= qte_pkg::wrap_off(ang_r[ANG_PITCH], pitch_off_r);
      out_roll_r  <= qte_pkg::wrap_off(ang_r[ANG_ROLL], roll_off_r);
      out_yaw_r   <= qte_pkg::wrap_off(ang_r[ANG_YAW], yaw_off_r);
      out_rx_r    <= rate_q[0*RW +: RW];
      out_ry_r    <= rate_q[1*RW +: RW];
      out_rz_r    <= rate_q[2*RW +: RW];
    end
  end

  assign out_pitch_angle   = out_pitch_r;
  assign out_roll_angle    = out_roll_r;
  assign out_yaw_angle     = out_yaw_r;
  assign out_rate_x_scaled = out_rx_r;
  assign out_rate_y_scaled = out_ry_r;
  assign out_rate_z_scaled = out_rz_r;

  // ---------------------------------------------------------------------
  // Checks
  logic ang_ok;
  logic out_ok;

  assign ang_ok = (ang_r[ANG_PITCH] <= ANG_HALF) && (ang_r[ANG_PITCH] >= -ANG_HALF) &&
                  (ang_r[ANG_ROLL] <= ANG_HALF) && (ang_r[ANG_ROLL] >= -ANG_HALF) &&
                  (ang_r[ANG_YAW] <= ANG_HALF) && (ang_r[ANG_YAW] >= -ANG_HALF);
  assign out_ok = (out_pitch_r <= ANG_MAX) && (out_pitch_r >= -ANG_MAX) &&
                  (out_roll_r <= ANG_MAX) && (out_roll_r >= -ANG_MAX) &&
                  (out_yaw_r <= ANG_MAX) && (out_yaw_r >= -ANG_MAX);

  `ASSERT_IMPL(a_sqrt_bound, clk, rst_n, vld_r[SQ_LAST], sq_w[SN].r <= SW'(ONE_V))
  `ASSERT_IMPL(a_ang_half, clk, rst_n, vld_r[LAT-1], ang_ok)
  `ASSERT_IMPL(a_out_range, clk, rst_n, out_valid_r, out_ok)
  `ASSERT_NEXT(a_frozen, clk, rst_n, out_valid_r && out_stall, $stable(vld_r))

endmodule

/* rtl/core/qte_delay.sv */
// Enabled shift line that carries side data beside the cell chains.
// Depends on nothing.
module qte_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  // Shift one tap per advance
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule

/* rtl/core/qte_sqrt_cell.sv */
// One cell of the pipelined integer square root: settles one root bit.
// Depends on qte_pkg.
module qte_sqrt_cell #(
  parameter int K = 0
) (
  input  logic           clk,
  input  logic           en,
  input  qte_pkg::sqrt_t d_in,
  output qte_pkg::sqrt_t d_out
);

  localparam int SW = qte_pkg::SQ_W;
  localparam logic [SW-1:0] BIT = SW'(1) << (2 * K);

  qte_pkg::sqrt_t d_r;
  qte_pkg::sqrt_t d_nxt;
  logic [SW:0]    trial;

  // Restoring step with trial r + 4^K
  always_comb begin
    d_nxt = d_in;
    trial = {1'b0, d_in.r} + {1'b0, BIT};
    if ({1'b0, d_in.v} >= trial) begin
      d_nxt.v = d_in.v - trial[SW-1:0];
      d_nxt.r = (d_in.r >> 1) + BIT;
    end else begin
      d_nxt.r = d_in.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

/* rtl/core/qte_div_cell.sv */
// One cell of the pipelined restoring divider: settles one quotient bit.
// Depends on qte_pkg.
module qte_div_cell #(
  parameter int BIT = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qte_pkg::CFG_W-1:0]   divisor,
  input  qte_pkg::div_t               d_in,
  output qte_pkg::div_t               d_out
);

  localparam int DW = qte_pkg::CFG_W;

  qte_pkg::div_t d_r;
  qte_pkg::div_t d_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  // Shift in the next numerator bit, subtract when it fits
  always_comb begin
    d_nxt = d_in;
    trial = {d_in.rem, d_in.num[BIT]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      d_nxt.rem      = diff[DW-1:0];
      d_nxt.quo[BIT] = 1'b1;
    end else begin
      d_nxt.rem = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

/* rtl/core/qte_cordic_cell.sv */
// One vectoring CORDIC cell: rotates toward y = 0 by atan(2^-STAGE).
// Depends on qte_pkg (arctangent table, cell type).
module qte_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             en,
  input  qte_pkg::cordic_t d_in,
  output qte_pkg::cordic_t d_out
);

  localparam int ZW = qte_pkg::ZW;
  localparam logic signed [ZW-1:0] ATAN = ZW'(qte_pkg::ATAN_TAB[STAGE]);

  qte_pkg::cordic_t d_r;
  qte_pkg::cordic_t d_nxt;

  // Direction from the sign of y; zero y counts as positive
  always_comb begin
    d_nxt = d_in;
    if (!d_in.y[qte_pkg::CW-1]) begin
      d_nxt.x = d_in.x + (d_in.y >>> STAGE);
      d_nxt.y = d_in.y - (d_in.x >>> STAGE);
      d_nxt.z = d_in.z + ATAN;
    end else begin
      d_nxt.x = d_in.x - (d_in.y >>> STAGE);
      d_nxt.y = d_in.y + (d_in.x >>> STAGE);
      d_nxt.z = d_in.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule
